// ===== rtl/core/salted_password_digest_macros.svh =====
// Assertion macros for the salted password digest checker
`ifndef SALTED_PASSWORD_DIGEST_MACROS_SVH
`define SALTED_PASSWORD_DIGEST_MACROS_SVH

// checked only while out of reset
`define SPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/spd_pkg.sv =====
// Shared types, constants and MD5 tables for the salted password digest
package spd_pkg;

  localparam int DIG_N  = 10;  // decimal digits of a 32-bit magnitude
  localparam int ROUNDS = 64;

  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;  // ceil(2^35 / 10)
  localparam int          RECIP_SH = 35;

  localparam logic [7:0] ZERO_MARK  = 8'h66;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] WORD_MUL [4] = '{32'h0003407f, 32'h000340ff,
                                           32'h000340d3, 32'h0003433d};
  localparam logic [31:0] WORD_ADD [4] = '{32'h00269735, 32'h00269741,
                                           32'h00269935, 32'h00269ACD};

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
  } md_state_t;

  localparam md_state_t MD_IV = '{d: 32'h10325476, c: 32'h98badcfe,
                                  b: 32'hefcdab89, a: 32'h67452301};

  localparam logic [31:0] MD_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int MD_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                               4, 11, 16, 23, 6, 10, 15, 21};

  // message word used by round i
  function automatic logic [3:0] md_g(input int i);
    int g;
    unique case (i >> 4)
      0:       g = i;
      1:       g = 5 * i + 1;
      2:       g = 3 * i + 5;
      default: g = 7 * i;
    endcase
    return 4'(g & 15);
  endfunction

  function automatic int md_shift(input int i);
    return MD_S[((i >> 4) << 2) | (i & 3)];
  endfunction

endpackage

// ===== rtl/core/spd_prep.sv =====
// Password scramble, salt to decimal conversion and MD5 block assembly
module spd_prep (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [63:0]  pw_lo_i,
  input  logic [63:0]  pw_hi_i,
  input  logic [31:0]  salt_i,
  output logic         valid_o,
  output logic [511:0] block_o
);
  import spd_pkg::*;

  typedef logic [DIG_N-1:0][3:0] digs_t;

  // stage 0: word scramble
  logic [127:0] pw_q, scr_q, scr_d, pw_d;
  // stages 0..DIG_N: salt magnitude, then one decimal digit per stage from stage 1
  logic [DIG_N:0]  v_q;
  logic [31:0]     mag_q [DIG_N+1];
  logic [31:0]     mag_d [DIG_N+1];
  logic            neg_q [DIG_N+1];
  logic [127:0]    pre_q [DIG_N+1];
  logic [127:0]    pre_d [DIG_N+1];
  digs_t           dig_q [DIG_N+1];
  digs_t           dig_d [DIG_N+1];
  // assembly stage
  logic            blk_v_q;
  logic [511:0]    blk_q, blk_d;

  always_comb begin
    pw_d = {pw_hi_i, pw_lo_i};
    for (int w = 0; w < 4; w++) begin
      scr_d[32*w +: 32] = pw_d[32*w +: 32] * WORD_MUL[w] + WORD_ADD[w];
    end
  end

  // chained byte XOR, a zero running value marked in the pre-image only; divide-by-ten salt digits
  always_comb begin
    logic [63:0] prod;
    logic [31:0] quo, rem;
    logic [31:0] su;
    logic [7:0]  run;
    su = salt_i;
    mag_d[0] = su[31] ? (~su + 32'd1) : su;
    pre_d[0] = '0;
    dig_d[0] = '0;
    run = '0;
    for (int i = 0; i < 16; i++) begin
      run = run ^ scr_q[8*i +: 8] ^ pw_q[8*i +: 8];
      pre_d[1][8*i +: 8] = (run != 8'd0) ? run : ZERO_MARK;
    end
    for (int k = 1; k <= DIG_N; k++) begin
      prod = 64'(mag_q[k-1]) * 64'(RECIP10);
      quo  = 32'(prod >> RECIP_SH);
      rem  = mag_q[k-1] - (quo << 3) - (quo << 1);
      mag_d[k] = quo;
      if (k > 1) begin
        pre_d[k] = pre_q[k-1];
      end
      dig_d[k] = (k == 1) ? digs_t'('0) : dig_q[k-1];
      dig_d[k][k-1] = rem[3:0];
    end
  end

  // salt text, padding and length placed after the 16-byte pre-image
  always_comb begin
    logic [3:0] nd;
    logic [3:0] sel;
    logic       neg;
    int         idx;
    logic [7:0] len;
    digs_t      dg;
    dg  = dig_q[DIG_N];
    neg = neg_q[DIG_N];
    nd  = 4'd1;
    for (int d = 1; d < DIG_N; d++) begin
      if (dg[d] != 4'd0) nd = 4'(d + 1);
    end
    blk_d = '0;
    blk_d[127:0] = pre_q[DIG_N];
    for (int j = 0; j < 12; j++) begin
      idx = j - int'(neg);
      sel = 4'(int'(nd) - 1 - idx);
      if (neg && j == 0) begin
        blk_d[128 + 8*j +: 8] = CHAR_MINUS;
      end else if (idx < int'(nd)) begin
        blk_d[128 + 8*j +: 8] = CHAR_ZERO + {4'd0, dg[sel]};
      end else if (idx == int'(nd)) begin
        blk_d[128 + 8*j +: 8] = PAD_BYTE;
      end
    end
    len = 8'd16 + {7'd0, neg} + {4'd0, nd};
    blk_d[448 +: 32] = {21'd0, len, 3'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      blk_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[DIG_N-1:0], valid_i};
      blk_v_q <= v_q[DIG_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pw_q     <= pw_d;
      scr_q    <= scr_d;
      mag_q[0] <= mag_d[0];
      neg_q[0] <= salt_i[31];
      pre_q[0] <= pre_d[0];
      dig_q[0] <= dig_d[0];
      for (int k = 1; k <= DIG_N; k++) begin
        mag_q[k] <= mag_d[k];
        neg_q[k] <= neg_q[k-1];
        pre_q[k] <= pre_d[k];
        dig_q[k] <= dig_d[k];
      end
      blk_q <= blk_d;
    end
  end

  assign valid_o = blk_v_q;
  assign block_o = blk_q;

endmodule

// ===== rtl/core/spd_md5.sv =====
// MD5 compression, one round per pipeline stage
module spd_md5 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [511:0]        block_i,
  output logic                valid_o,
  output spd_pkg::md_state_t  state_o
);
  import spd_pkg::*;

  logic [ROUNDS-1:0] v_q;
  md_state_t         st_q [ROUNDS];
  md_state_t         st_d [ROUNDS];
  logic [511:0]      m_q  [ROUNDS];
  logic [511:0]      m_d  [ROUNDS];

  always_comb begin
    md_state_t   s;
    logic [511:0] m;
    logic [31:0] f, t, r;
    logic [3:0]  g;
    int          sh;
    for (int i = 0; i < ROUNDS; i++) begin
      s = (i == 0) ? MD_IV : st_q[(i == 0) ? 0 : i - 1];
      m = (i == 0) ? block_i : m_q[(i == 0) ? 0 : i - 1];
      unique case (i >> 4)
        0:       f = (s.b & s.c) | (~s.b & s.d);
        1:       f = (s.d & s.b) | (~s.d & s.c);
        2:       f = s.b ^ s.c ^ s.d;
        default: f = s.c ^ (s.b | ~s.d);
      endcase
      g  = md_g(i);
      sh = md_shift(i);
      t  = s.a + f + MD_K[i] + m[{g, 5'd0} +: 32];
      r  = (t << sh) | (t >> (32 - sh));
      st_d[i] = '{d: s.c, c: s.b, b: s.b + r, a: s.d};
      m_d[i]  = m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ROUNDS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < ROUNDS; i++) begin
        st_q[i] <= st_d[i];
        m_q[i]  <= m_d[i];
      end
    end
  end

  assign valid_o = v_q[ROUNDS-1];
  assign state_o = st_q[ROUNDS-1];

endmodule

// ===== rtl/core/salted_password_digest.sv =====
// Top level of the salted password digest pipeline
// Salted password digest: takes one password and salt per cycle and returns
// the MD5 digest of the scrambled password followed by the salt as decimal
// text. The pipeline has one scramble stage, ten salt-digit stages (one
// divide-by-ten each), one block assembly stage, 64 MD5 round stages and the
// output register that adds the initial state. Sustained rate is one item
// per cycle; the whole pipeline holds while a result waits on the output.
module salted_password_digest (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,   // password_lo[63:0], password_hi[127:64],
                                       // salt[159:128]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_lo[63:0], digest_hi[127:64]
);
  import spd_pkg::*;

  logic         en;
  logic         prep_v, md_v;
  logic [511:0] block;
  md_state_t    st;
  logic         out_v_q;
  logic [127:0] dig_q, dig_d;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  spd_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .pw_lo_i (s_axis_tdata[63:0]),
    .pw_hi_i (s_axis_tdata[127:64]),
    .salt_i  (s_axis_tdata[159:128]),
    .valid_o (prep_v),
    .block_o (block)
  );

  spd_md5 u_md5 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_v),
    .block_i (block),
    .valid_o (md_v),
    .state_o (st)
  );

  assign dig_d = {st.d + MD_IV.d, st.c + MD_IV.c, st.b + MD_IV.b, st.a + MD_IV.a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= md_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dig_q <= dig_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = dig_q;

endmodule

// ===== rtl/core/spd_checker.sv =====
// Port-level checks for the salted password digest, bound to the top level
`include "salted_password_digest_macros.svh"

module spd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [159:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  logic out_slot, out_stall;

  assign out_slot  = !m_axis_tvalid || m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `SPD_ASSERT(a_ready_follows_out, s_axis_tready == out_slot, "input ready wrong")
  `SPD_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed")
  `SPD_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !m_axis_tvalid, "result shown during reset")
  `SPD_ASSERT(a_first_empty, $past(!rst_ni) |-> !m_axis_tvalid && s_axis_tready, "not empty")

endmodule

bind salted_password_digest spd_checker u_spd_checker (.*);

// ===== test/salted_password_digest_tb.sv =====
// Testbench for the salted password digest pipeline: directed and random items
module salted_password_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 730;
  localparam int LATENCY    = 77;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 5000;

  localparam logic [31:0] SCR_MUL [4] = '{32'h0003407f, 32'h000340ff,
                                          32'h000340d3, 32'h0003433d};
  localparam logic [31:0] SCR_ADD [4] = '{32'h00269735, 32'h00269741,
                                          32'h00269935, 32'h00269acd};
  localparam int ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                              4, 11, 16, 23, 6, 10, 15, 21};

  typedef struct packed {
    logic [31:0] salt;
    logic [63:0] pw_hi;
    logic [63:0] pw_lo;
  } login_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } digest_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  digest_t digest_q[$];
  int      errors;
  int      idle_cycles;
  bit      hold_req;

  salted_password_digest u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // scramble, chain, append salt text, then one MD5 block
  function automatic digest_t login_digest(input login_t it);
    logic [7:0]  pw [16];
    logic [7:0]  blk [64];
    logic [7:0]  dig [10];
    logic [31:0] w, mag, f, t, a, b, c, d;
    logic [31:0] m [16];
    logic [7:0]  run;
    int          len, nd, g;
    digest_t     r;
    for (int i = 0; i < 8; i++) begin
      pw[i]     = it.pw_lo[8*i +: 8];
      pw[8 + i] = it.pw_hi[8*i +: 8];
    end
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    run = 8'h00;
    for (int i = 0; i < 4; i++) begin
      w = {pw[4*i+3], pw[4*i+2], pw[4*i+1], pw[4*i]} * SCR_MUL[i] + SCR_ADD[i];
      for (int j = 0; j < 4; j++) begin
        run = run ^ w[8*j +: 8] ^ pw[4*i+j];
        blk[4*i+j] = (run == 8'h00) ? 8'h66 : run;
      end
    end
    len = 16;
    mag = it.salt;
    if (it.salt[31]) begin
      blk[len++] = 8'h2d;
      mag = 32'h0 - it.salt;
    end
    nd = 0;
    do begin
      dig[nd++] = 8'h30 + 8'(mag % 10);
      mag = mag / 10;
    end while (mag != 0 && nd < 10);
    while (nd > 0) blk[len++] = dig[--nd];
    blk[len] = 8'h80;
    blk[56] = 8'(len * 8);
    for (int i = 0; i < 16; i++) m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5*i + 1) & 15;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3*i + 5) & 15;
      end else begin
        f = c ^ (b | ~d); g = (7*i) & 15;
      end
      t = d; d = c; c = b;
      b = b + rotl(a + f + spd_pkg::MD_K[i] + m[g], ROT[((i >> 4) << 2) | (i & 3)]);
      a = t;
    end
    r.lo = {32'hefcdab89 + b, 32'h67452301 + a};
    r.hi = {32'h10325476 + d, 32'h98badcfe + c};
    return r;
  endfunction

  // scoreboard and watchdog
  always @(posedge clk_i) begin
    digest_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        digest_q.push_back(login_digest(login_t'(s_axis_tdata)));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (digest_q.size() == 0) begin
          $error("unexpected digest %h", got);
          errors++;
        end else begin
          want = digest_q.pop_front();
          if (got.lo !== want.lo) begin
            $error("digest_lo: expected %h, got %h", want.lo, got.lo);
            errors++;
          end
          if (got.hi !== want.hi) begin
            $error("digest_hi: expected %h, got %h", want.hi, got.hi);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, bursts without stalls, one long hold-off
  initial begin
    int stall;
    bit burst;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  login_t directed [] = '{
    '{salt: 32'h00000000, pw_hi: 64'h0, pw_lo: 64'h0},
    '{salt: 32'hffffffff, pw_hi: '1, pw_lo: '1},
    '{salt: 32'h7fffffff, pw_hi: 64'h0, pw_lo: '1},
    '{salt: 32'h80000000, pw_hi: '1, pw_lo: 64'h0},
    '{salt: 32'd9, pw_hi: 64'h0f0e0d0c0b0a0908, pw_lo: 64'h0706050403020100},
    '{salt: 32'd10, pw_hi: 64'h5555555555555555, pw_lo: 64'haaaaaaaaaaaaaaaa},
    '{salt: -32'sd10, pw_hi: 64'h6472617773736170, pw_lo: 64'h64726f7773736170},
    '{salt: 32'd999999999, pw_hi: 64'h8000000000000000, pw_lo: 64'h1},
    '{salt: 32'd1000000000, pw_hi: 64'h1, pw_lo: 64'h8000000000000000},
    '{salt: -32'sd2147483647, pw_hi: 64'h0000000000000066, pw_lo: 64'h66},
    '{salt: 32'd1, pw_hi: 64'h00000000ffffffff, pw_lo: 64'hffffffff00000000},
    '{salt: -32'sd1000000000, pw_hi: 64'h123456789abcdef0, pw_lo: 64'hfedcba9876543210}
  };

  task automatic send_login(input login_t it, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_salt();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'($urandom_range(0, 20)) - 32'd10;
      3: return 32'($urandom_range(0, 99999));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    login_t it;
    bit     burst;
    errors        = 0;
    idle_cycles   = 0;
    hold_req      = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[i]) send_login(directed[i], 1'b0);
    for (int n = 0; n < N_RANDOM; n++) begin
      // receiver stalled: sender keeps offering back to back
      if (n == 100) hold_req = 1'b1;
      // sender pauses until every outstanding result has come back
      if (n == 400) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (digest_q.size() != 0);
      end
      if ($urandom_range(0, 29) == 0) burst = ~burst;
      it.pw_lo = {$urandom, $urandom};
      it.pw_hi = {$urandom, $urandom};
      it.salt  = pick_salt();
      send_login(it, burst || (n >= 100 && n < 200));
    end
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 20) @(negedge clk_i);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spd_pkg.sv
rtl/core/spd_prep.sv
rtl/core/spd_md5.sv
rtl/core/salted_password_digest.sv
rtl/core/spd_checker.sv
test/salted_password_digest_tb.sv
